@@ sv/aus_pkg.sv @@
// shared constants and types for the annex b access unit splitter
`default_nettype none

package aus_pkg;

    // default width of the stream byte counter
    localparam int AUS_POS_BITS = 32;

    // window of recent bytes: candidate start code byte plus six after it
    localparam int WIN_BYTES = 7;
    localparam int WIN_BITS  = 8 * WIN_BYTES;
    localparam int FILL_BITS = 3;

    // width of offsets on the result port
    localparam int OUT_BITS = 32;

    // nal type width after decode
    localparam int TYPE_BITS = 6;

    // skip count after a start code (3-byte or 4-byte form)
    localparam logic [2:0] STEP_SHORT = 3'd3;
    localparam logic [2:0] STEP_LONG  = 3'd4;

    // codec modes
    localparam logic MODE_H264 = 1'b0;
    localparam logic MODE_HEVC = 1'b1;

    // h.264 nal types
    localparam logic [TYPE_BITS-1:0] H264_SLICE     = 6'd1;
    localparam logic [TYPE_BITS-1:0] H264_IDR       = 6'd5;
    localparam logic [TYPE_BITS-1:0] H264_SPS       = 6'd7;
    localparam logic [TYPE_BITS-1:0] H264_AUD       = 6'd9;
    localparam logic [7:0]           H264_TYPE_MASK = 8'h1f;

    // hevc nal types
    localparam logic [TYPE_BITS-1:0] HEVC_SLICE_LIMIT = 6'd21;
    localparam logic [TYPE_BITS-1:0] HEVC_IRAP_FIRST  = 6'd16;
    localparam logic [TYPE_BITS-1:0] HEVC_IRAP_LAST   = 6'd20;
    localparam logic [TYPE_BITS-1:0] HEVC_VPS         = 6'd32;
    localparam logic [TYPE_BITS-1:0] HEVC_SPS         = 6'd33;
    localparam logic [TYPE_BITS-1:0] HEVC_AUD         = 6'd35;

    // control flags from the byte window stage to the decision stage
    typedef struct packed {
        logic valid;   // a freshly shifted byte waits to be examined
        logic full;    // window holds seven stream bytes
    } t_win_ctl;

endpackage

`default_nettype wire

@@ sv/aus_window.sv @@
// input stage: byte window shift register, fill count and byte offset counter
`default_nettype none

module aus_window
    import aus_pkg::*;
#(
    parameter int POS_BITS = AUS_POS_BITS
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire logic [7:0]          i_stream_byte,
    input  wire logic                i_take,
    output logic                     o_in_stall,
    output t_win_ctl                 o_ctl,
    output logic [WIN_BITS-1:0]      o_window,
    output logic [POS_BITS-1:0]      o_here
);

    logic                 r_valid;
    logic [FILL_BITS-1:0] r_fill;
    logic [WIN_BITS-1:0]  r_window;
    logic [POS_BITS-1:0]  r_pos;
    logic [POS_BITS-1:0]  r_here;
    logic                 accept;

    // stage is held while the decision stage cannot take it
    assign o_in_stall = r_valid && !i_take;
    assign accept     = i_in_valid && !o_in_stall;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_fill  <= '0;
            r_pos   <= '0;
        end else begin
            r_valid <= accept || (r_valid && !i_take);
            if (accept) begin
                r_pos <= r_pos + POS_BITS'(1);
                if (r_fill != FILL_BITS'(WIN_BYTES)) begin
                    r_fill <= r_fill + FILL_BITS'(1);
                end
            end
        end
    end

    // byte window and offset of the newest byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= '0;
            r_here   <= '0;
        end else if (accept) begin
            r_window <= {r_window[WIN_BITS-9:0], i_stream_byte};
            r_here   <= r_pos;
        end
    end

    assign o_ctl.valid = r_valid;
    assign o_ctl.full  = (r_fill == FILL_BITS'(WIN_BYTES));
    assign o_window    = r_window;
    assign o_here      = r_here;

endmodule

`default_nettype wire

@@ sv/aus_unit.sv @@
// decision stage: start code match, nal decode, unit tracking and result register
`default_nettype none

module aus_unit
    import aus_pkg::*;
#(
    parameter int POS_BITS = AUS_POS_BITS
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_valid,
    input  wire logic [0:0]          i_cfg_data,
    input  wire t_win_ctl            i_ctl,
    input  wire logic [WIN_BITS-1:0] i_window,
    input  wire logic [POS_BITS-1:0] i_here,
    input  wire logic                i_out_stall,
    output logic                     o_take,
    output logic                     o_out_valid,
    output logic [OUT_BITS-1:0]      o_unit_begin,
    output logic [OUT_BITS-1:0]      o_unit_end,
    output logic                     o_is_key
);

    logic                  r_codec_mode;
    logic [2:0]            r_pending;
    logic [TYPE_BITS-1:0]  r_prev_type;
    logic                  r_slice_seen;
    logic                  r_key_seen;
    logic [POS_BITS-1:0]   r_begin;
    logic                  r_begin_known;
    logic                  r_out_valid;
    logic [OUT_BITS-1:0]   r_unit_begin;
    logic [OUT_BITS-1:0]   r_unit_end;
    logic                  r_is_key;

    logic [7:0]            b0, b1, b2, b3, b4, b5, b6;
    logic                  sc_short, sc_long;
    logic [7:0]            hdr, nxt1, nxt2;
    logic [TYPE_BITS-1:0]  nal_type;
    logic                  first_slice;
    logic [2:0]            step;
    logic                  process, found, skipping, unit_end;
    logic                  is_slice, is_key, is_delim, prev_delim;
    logic [POS_BITS-1:0]   pos, beg;
    logic [POS_BITS+OUT_BITS-1:0] pos_ext, beg_ext;

    logic [2:0]            n_pending;
    logic                  n_slice_seen;
    logic                  n_key_seen;
    logic [POS_BITS-1:0]   n_begin;

    // configuration register, always ready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_codec_mode <= MODE_H264;
        end else if (i_cfg_valid) begin
            r_codec_mode <= i_cfg_data[0];
        end
    end

    // window bytes, oldest first
    assign b0 = i_window[8*6 +: 8];
    assign b1 = i_window[8*5 +: 8];
    assign b2 = i_window[8*4 +: 8];
    assign b3 = i_window[8*3 +: 8];
    assign b4 = i_window[8*2 +: 8];
    assign b5 = i_window[8*1 +: 8];
    assign b6 = i_window[8*0 +: 8];

    // start code match, short form wins
    assign sc_short = (b0 == 8'h00) && (b1 == 8'h00) && (b2 == 8'h01);
    assign sc_long  = (b0 == 8'h00) && (b1 == 8'h00) && (b2 == 8'h00) && (b3 == 8'h01);
    assign hdr      = sc_short ? b3 : b4;
    assign nxt1     = sc_short ? b4 : b5;
    assign nxt2     = sc_short ? b5 : b6;
    assign step     = sc_short ? STEP_SHORT : STEP_LONG;

    // stage handshake
    assign o_take   = !r_out_valid || !i_out_stall;
    assign process  = i_ctl.valid && o_take;
    assign skipping = i_ctl.full && (r_pending != 3'd0);
    assign found    = i_ctl.full && (r_pending == 3'd0) && (sc_short || sc_long);

    // nal header decode and per-codec classes
    always_comb begin
        if (r_codec_mode == MODE_H264) begin
            nal_type    = TYPE_BITS'(hdr & H264_TYPE_MASK);
            first_slice = nxt1[7];
            is_slice    = (nal_type == H264_SLICE) || (nal_type == H264_IDR);
            is_key      = (nal_type == H264_IDR);
            is_delim    = (nal_type == H264_AUD) || (nal_type == H264_SPS);
            prev_delim  = (r_prev_type == H264_AUD) || (r_prev_type == H264_SPS);
        end else begin
            nal_type    = hdr[6:1];
            first_slice = nxt2[7];
            is_slice    = (nal_type < HEVC_SLICE_LIMIT);
            is_key      = (nal_type >= HEVC_IRAP_FIRST) && (nal_type <= HEVC_IRAP_LAST);
            is_delim    = (nal_type == HEVC_AUD) || (nal_type == HEVC_VPS)
                       || (nal_type == HEVC_SPS);
            prev_delim  = (r_prev_type == HEVC_AUD) || (r_prev_type == HEVC_VPS)
                       || (r_prev_type == HEVC_SPS);
        end
    end

    // offsets: candidate byte arrived six bytes before the newest
    assign pos      = i_here - POS_BITS'(6);
    assign beg      = r_begin_known ? r_begin : pos;
    assign pos_ext  = {{OUT_BITS{1'b0}}, pos};
    assign beg_ext  = {{OUT_BITS{1'b0}}, beg};

    // unit boundary decision
    assign unit_end = r_slice_seen && (prev_delim || is_delim || (is_slice && first_slice));

    // next unit state for a matched start code
    always_comb begin
        n_pending    = r_pending;
        n_slice_seen = r_slice_seen;
        n_key_seen   = r_key_seen;
        n_begin      = beg;
        if (found) begin
            n_pending = step;
            if (unit_end) begin
                n_begin      = pos;
                n_slice_seen = is_slice;
                n_key_seen   = is_slice && is_key;
            end else if (is_slice) begin
                n_slice_seen = 1'b1;
                if (!r_slice_seen) begin
                    n_key_seen = is_key;
                end
            end
        end else if (skipping) begin
            n_pending = r_pending - 3'd1;
        end
    end

    // unit tracking state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending     <= '0;
            r_prev_type   <= '0;
            r_slice_seen  <= 1'b0;
            r_key_seen    <= 1'b0;
            r_begin       <= '0;
            r_begin_known <= 1'b0;
        end else if (process) begin
            r_pending    <= n_pending;
            r_slice_seen <= n_slice_seen;
            r_key_seen   <= n_key_seen;
            if (found) begin
                r_prev_type   <= nal_type;
                r_begin       <= n_begin;
                r_begin_known <= 1'b1;
            end
        end
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_take) begin
            r_out_valid <= process && found && unit_end;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (process && found && unit_end) begin
            r_unit_begin <= beg_ext[OUT_BITS-1:0];
            r_unit_end   <= pos_ext[OUT_BITS-1:0];
            r_is_key     <= r_key_seen;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_unit_begin = r_unit_begin;
    assign o_unit_end   = r_unit_end;
    assign o_is_key     = r_is_key;

endmodule

`default_nettype wire

@@ sv/annexb_access_unit_splitter.sv @@
// Top level of the Annex B access unit splitter.
// Path: an accepted byte is registered in the window stage, then examined by the
// decision stage when it takes it; a result it causes is held in the result register.
// Throughput: one stream byte per cycle, set by the two register stages;
// stalls only while both stages are full and the output is stalled.
// Reset: synchronous active low; clears byte counter, unit state, mode and valids.
`default_nettype none

module annexb_access_unit_splitter
    import aus_pkg::*;
#(
    parameter int POS_BITS = AUS_POS_BITS
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic [7:0]          i_stream_byte,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [0:0]          i_cfg_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic [OUT_BITS-1:0]      o_unit_begin,
    output logic [OUT_BITS-1:0]      o_unit_end,
    output logic                     o_is_key
);

    t_win_ctl              win_ctl;
    logic [WIN_BITS-1:0]   window;
    logic [POS_BITS-1:0]   here;
    logic                  take;

    // configuration register is always writable
    assign o_cfg_ready = 1'b1;

    // byte window input stage
    aus_window #(
        .POS_BITS (POS_BITS)
    ) u_window (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_stream_byte (i_stream_byte),
        .i_take        (take),
        .o_in_stall    (o_in_stall),
        .o_ctl         (win_ctl),
        .o_window      (window),
        .o_here        (here)
    );

    // decision and result stage
    aus_unit #(
        .POS_BITS (POS_BITS)
    ) u_unit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_ctl        (win_ctl),
        .i_window     (window),
        .i_here       (here),
        .i_out_stall  (i_out_stall),
        .o_take       (take),
        .o_out_valid  (o_out_valid),
        .o_unit_begin (o_unit_begin),
        .o_unit_end   (o_unit_end),
        .o_is_key     (o_is_key)
    );

endmodule

`default_nettype wire

@@ sv/aus_checker.sv @@
// port-level checker for the access unit splitter and its bind
`default_nettype none

module aus_checker
    import aus_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                o_in_stall,
    input  wire logic                o_out_valid,
    input  wire logic                i_out_stall,
    input  wire logic [OUT_BITS-1:0] o_unit_begin,
    input  wire logic [OUT_BITS-1:0] o_unit_end,
    input  wire logic                o_is_key
);

    // a stalled request stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result request dropped while stalled");

    // a stalled request keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            $stable(o_unit_begin) && $stable(o_unit_end) && $stable(o_is_key))
        else $error("result payload changed while stalled");

    // start code skip keeps results at least a few bytes apart
    a_no_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall |=> !o_out_valid)
        else $error("two results in consecutive cycles");

    // with an empty result register the input never stalls
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled with no result waiting");

endmodule

bind annexb_access_unit_splitter aus_checker u_aus_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_unit_begin (o_unit_begin),
    .o_unit_end   (o_unit_end),
    .o_is_key     (o_is_key)
);

`default_nettype wire
